[rtl/rcfd_pkg.sv]
// Package for the remote control frame decoder.
// Holds frame types, register codes, reset values and the channel shaping function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcfd_pkg;

  // Frame geometry.
  localparam int unsigned FRAME_BYTES = 18;
  localparam int unsigned CNT_W       = 5;

  // Input item codes.
  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_IDLE = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned CFG_DATA_W        = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_LIMIT = 2'd2;

  // Configuration reset values.
  localparam logic [10:0] CENTER_OFFSET_RST = 11'd1024;
  localparam logic [9:0]  DEAD_ZONE_RST     = 10'd15;
  localparam logic [9:0]  CHANNEL_LIMIT_RST = 10'd660;

  // Frame queue geometry.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // One complete raw frame, byte 0 in the lowest slot.
  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  // Live configuration handed to the decode stage.
  typedef struct packed {
    logic [10:0] center_offset;
    logic [9:0]  dead_zone;
    logic [9:0]  channel_limit;
  } cfg_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Front status for checking.
  typedef struct packed {
    logic [CNT_W-1:0] byte_count;
  } front_status_t;

  // Center a raw channel, force small magnitudes to zero, then clamp.
  function automatic logic signed [10:0] shape_channel(
    input logic [10:0] raw,
    input cfg_t        cfg
  );
    logic signed [11:0] v;
    logic signed [11:0] lim;
    logic [10:0]        mag;
    v   = $signed({1'b0, raw}) - $signed({1'b0, cfg.center_offset});
    mag = v[11] ? 11'(-v) : v[10:0];
    lim = $signed({2'b00, cfg.channel_limit});
    if (mag < {1'b0, cfg.dead_zone}) begin
      v = '0;
    end
    if (v > lim) begin
      v = lim;
    end
    if (v < -lim) begin
      v = -lim;
    end
    return v[10:0];
  endfunction

endpackage

`default_nettype wire

[rtl/rcfd_front.sv]
// Front end of the frame decoder: byte capture, byte counting and frame hand-off.
// Depends on rcfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcfd_front import rcfd_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          mode_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire queue_status_t q_status_i,
  output logic               push_o,
  output frame_t             frame_o,
  output front_status_t      status_o
);

  logic [CNT_W-1:0] byte_count_q, byte_count_d;
  frame_t           frame_q;
  logic             accept;
  logic             full;

  // Take a request whenever the queue has room for a finished frame.
  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (byte_count_q == CNT_W'(FRAME_BYTES));

  // An idle event after exactly one frame of bytes hands the frame on.
  assign push_o   = accept && (mode_i == MODE_IDLE) && full;
  assign frame_o  = frame_q;
  assign status_o = '{byte_count: byte_count_q};

  // Byte counter saturates one past the frame size so long frames drop.
  always_comb begin
    byte_count_d = byte_count_q;
    if (accept) begin
      if (mode_i == MODE_IDLE) begin
        byte_count_d = '0;
      end else if (byte_count_q < CNT_W'(FRAME_BYTES)) begin
        byte_count_d = byte_count_q + CNT_W'(1);
      end else if (full) begin
        byte_count_d = CNT_W'(FRAME_BYTES + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
    end else begin
      byte_count_q <= byte_count_d;
    end
  end

  // Frame store: each data byte lands at the current count.
  always_ff @(posedge clk_i) begin
    if (accept && (mode_i == MODE_DATA) && (byte_count_q < CNT_W'(FRAME_BYTES))) begin
      frame_q[byte_count_q] <= rx_byte_i;
    end
  end

endmodule

`default_nettype wire

[rtl/rcfd_queue.sv]
// Two-entry queue of complete raw frames between the front and the decode stage.
// Depends on rcfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcfd_queue import rcfd_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire frame_t frame_i,
  input  wire logic   pop_i,
  output frame_t      frame_o,
  output queue_status_t status_o
);

  frame_t            entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign frame_o        = entry_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= frame_i;
    end
  end

endmodule

`default_nettype wire

[rtl/rcfd_back.sv]
// Decode stage: unpacks a raw frame, shapes the stick channels, holds the result.
// Depends on rcfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcfd_back import rcfd_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cfg_t          cfg_i,
  input  wire frame_t        frame_i,
  input  wire queue_status_t q_status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic signed [10:0] stick_right_x_o,
  output logic signed [10:0] stick_right_y_o,
  output logic signed [10:0] stick_left_x_o,
  output logic signed [10:0] stick_left_y_o,
  output logic [3:0]         switches_o,
  output logic signed [15:0] mouse_x_o,
  output logic signed [15:0] mouse_y_o,
  output logic signed [15:0] mouse_z_o,
  output logic [7:0]         mouse_left_o,
  output logic [7:0]         mouse_right_o,
  output logic [15:0]        key_bits_o,
  output logic [15:0]        wheel_value_o
);

  logic        out_valid_q, out_valid_d;
  logic [10:0] ch0, ch1, ch2, ch3;

  // Load a new frame when the result register is empty or being taken.
  assign pop_o = !q_status_i.empty && (!out_valid_q || out_ready_i);

  // Stick channels are packed 11 bits each, little endian, from byte 0.
  assign ch0 = {frame_i[1][2:0], frame_i[0]};
  assign ch1 = {frame_i[2][5:0], frame_i[1][7:3]};
  assign ch2 = {frame_i[4][0], frame_i[3], frame_i[2][7:6]};
  assign ch3 = {frame_i[5][3:0], frame_i[4][7:1]};

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      stick_right_x_o <= shape_channel(ch0, cfg_i);
      stick_right_y_o <= shape_channel(ch1, cfg_i);
      stick_left_x_o  <= shape_channel(ch2, cfg_i);
      stick_left_y_o  <= shape_channel(ch3, cfg_i);
      switches_o      <= frame_i[5][7:4];
      mouse_x_o       <= {frame_i[7], frame_i[6]};
      mouse_y_o       <= {frame_i[9], frame_i[8]};
      mouse_z_o       <= {frame_i[11], frame_i[10]};
      mouse_left_o    <= frame_i[12];
      mouse_right_o   <= frame_i[13];
      key_bits_o      <= {frame_i[15], frame_i[14]};
      wheel_value_o   <= {frame_i[17], frame_i[16]};
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/remote_control_frame_decoder_top.sv]
// Remote control frame decoder top level: config registers, front, queue, decode stage.
// A frame-ending idle request queues its frame; the decode stage then registers the result.
// Throughput is one request per cycle while the queue has room, set by the capture front end.
// The two-entry frame queue lets the front keep taking bytes while a result waits.
// Reset is asynchronous, active low: byte count and queue clear, registers reload defaults.
// Depends on rcfd_pkg, rcfd_front, rcfd_queue and rcfd_back.
`timescale 1ns / 1ps
`default_nettype none

module remote_control_frame_decoder_top import rcfd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  mode_i,
  input  wire logic [7:0]            rx_byte_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic signed [10:0]         stick_right_x_o,
  output logic signed [10:0]         stick_right_y_o,
  output logic signed [10:0]         stick_left_x_o,
  output logic signed [10:0]         stick_left_y_o,
  output logic [3:0]                 switches_o,
  output logic signed [15:0]         mouse_x_o,
  output logic signed [15:0]         mouse_y_o,
  output logic signed [15:0]         mouse_z_o,
  output logic [7:0]                 mouse_left_o,
  output logic [7:0]                 mouse_right_o,
  output logic [15:0]                key_bits_o,
  output logic [15:0]                wheel_value_o
);

  cfg_t          cfg_q, cfg_d;
  queue_status_t q_status;
  front_status_t front_status;
  frame_t        push_frame;
  frame_t        pop_frame;
  logic          push;
  logic          pop;

  // Configuration writes; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CENTER_OFFSET: cfg_d.center_offset = cfg_wdata_i;
        CFG_DEAD_ZONE:     cfg_d.dead_zone     = cfg_wdata_i[9:0];
        CFG_CHANNEL_LIMIT: cfg_d.channel_limit = cfg_wdata_i[9:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{center_offset: CENTER_OFFSET_RST,
                 dead_zone:     DEAD_ZONE_RST,
                 channel_limit: CHANNEL_LIMIT_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Byte capture and frame hand-off.
  rcfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .rx_byte_i  (rx_byte_i),
    .q_status_i (q_status),
    .push_o     (push),
    .frame_o    (push_frame),
    .status_o   (front_status)
  );

  // Queue of complete frames.
  rcfd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .frame_i  (push_frame),
    .pop_i    (pop),
    .frame_o  (pop_frame),
    .status_o (q_status)
  );

  // Decode and result register.
  rcfd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .frame_i         (pop_frame),
    .q_status_i      (q_status),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .stick_right_x_o (stick_right_x_o),
    .stick_right_y_o (stick_right_y_o),
    .stick_left_x_o  (stick_left_x_o),
    .stick_left_y_o  (stick_left_y_o),
    .switches_o      (switches_o),
    .mouse_x_o       (mouse_x_o),
    .mouse_y_o       (mouse_y_o),
    .mouse_z_o       (mouse_z_o),
    .mouse_left_o    (mouse_left_o),
    .mouse_right_o   (mouse_right_o),
    .key_bits_o      (key_bits_o),
    .wheel_value_o   (wheel_value_o)
  );

  // A finished frame is never pushed into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && q_status.full))
    else $error("frame pushed into full queue");

  // The decode stage never loads from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop && q_status.empty))
    else $error("frame popped from empty queue");

  // The byte count saturates one past the frame size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_status.byte_count <= CNT_W'(FRAME_BYTES + 1))
    else $error("byte count out of range");

  // A push with nothing leaving leaves the queue non-empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> !q_status.empty)
    else $error("pushed frame lost");

endmodule

`default_nettype wire

[test/tb_top.sv]
// Testbench for the remote control frame decoder: directed frames, then random framed traffic.
// Every result is checked against a built-in decoder predictor or a directed row's frame.
// Depends on rcfd_pkg and remote_control_frame_decoder_top.
`timescale 1ns / 1ps

module tb_top;
  import rcfd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 232;

  // Index that maps to no register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // One decoded frame as the block presents it.
  typedef struct packed {
    logic signed [10:0] right_x;
    logic signed [10:0] right_y;
    logic signed [10:0] left_x;
    logic signed [10:0] left_y;
    logic [3:0]         switches;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [7:0]         btn_left;
    logic [7:0]         btn_right;
    logic [15:0]        keys;
    logic [15:0]        wheel;
  } decoded_frame_t;

  // One row of the directed stimulus: a request repeated reps times.
  typedef struct packed {
    logic           mode;
    logic [7:0]     data;
    logic [4:0]     reps;
    logic           has_frame;
    decoded_frame_t frame;
  } stim_row_t;

  // A frame of all ones under reset settings: every stick hits the positive limit.
  localparam decoded_frame_t ALL_ONES_FRAME = '{
    right_x: 11'sd660, right_y: 11'sd660, left_x: 11'sd660, left_y: 11'sd660,
    switches: 4'hF, mouse_x: -16'sd1, mouse_y: -16'sd1, mouse_z: -16'sd1,
    btn_left: 8'hFF, btn_right: 8'hFF, keys: 16'hFFFF, wheel: 16'hFFFF
  };

  // Idle with no bytes, a short frame, then a full frame of all ones.
  localparam stim_row_t DIRECTED_ROWS [5] = '{
    '{MODE_IDLE, 8'h00, 5'd1,  1'b0, '0},
    '{MODE_DATA, 8'hA5, 5'd2,  1'b0, '0},
    '{MODE_IDLE, 8'h3C, 5'd1,  1'b0, '0},
    '{MODE_DATA, 8'hFF, 5'd18, 1'b0, '0},
    '{MODE_IDLE, 8'hFF, 5'd1,  1'b1, ALL_ONES_FRAME}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  mode_i;
  logic [7:0]            rx_byte_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic signed [10:0]    stick_right_x_o;
  logic signed [10:0]    stick_right_y_o;
  logic signed [10:0]    stick_left_x_o;
  logic signed [10:0]    stick_left_y_o;
  logic [3:0]            switches_o;
  logic signed [15:0]    mouse_x_o;
  logic signed [15:0]    mouse_y_o;
  logic signed [15:0]    mouse_z_o;
  logic [7:0]            mouse_left_o;
  logic [7:0]            mouse_right_o;
  logic [15:0]           key_bits_o;
  logic [15:0]           wheel_value_o;

  // Predictor state: register copies, the frame store and its byte count.
  logic [10:0] cfg_center;
  logic [9:0]  cfg_dead;
  logic [9:0]  cfg_limit;
  logic [7:0]  rx_store [FRAME_BYTES];
  int          rx_count;

  decoded_frame_t pending_frames [$];
  logic [7:0]     tx_frame [FRAME_BYTES];
  bit             gaps_on;
  int             mismatches;
  int             requests_sent;
  int             frames_checked;
  int             cycles;

  remote_control_frame_decoder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .stick_right_x_o (stick_right_x_o),
    .stick_right_y_o (stick_right_y_o),
    .stick_left_x_o  (stick_left_x_o),
    .stick_left_y_o  (stick_left_y_o),
    .switches_o      (switches_o),
    .mouse_x_o       (mouse_x_o),
    .mouse_y_o       (mouse_y_o),
    .mouse_z_o       (mouse_z_o),
    .mouse_left_o    (mouse_left_o),
    .mouse_right_o   (mouse_right_o),
    .key_bits_o      (key_bits_o),
    .wheel_value_o   (wheel_value_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d frames outstanding.",
               cycles, pending_frames.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Center one raw channel, zero it inside the dead zone, then clamp.
  function automatic logic signed [10:0] center_stick(input logic [10:0] raw);
    int v;
    int mag;
    int lim;
    v   = int'(raw) - int'(cfg_center);
    mag = (v < 0) ? -v : v;
    lim = int'(cfg_limit);
    if (mag < int'(cfg_dead)) begin
      v = 0;
    end
    if (v > lim) begin
      v = lim;
    end
    if (v < -lim) begin
      v = -lim;
    end
    return 11'(v);
  endfunction

  // Advance the predicted frame store by one request; returns 1 when a frame decodes.
  function automatic bit decode_step(input logic m, input logic [7:0] d,
                                     output decoded_frame_t f);
    logic [47:0] head;
    f = '0;
    if (m == MODE_DATA) begin
      if (rx_count < FRAME_BYTES) begin
        rx_store[rx_count] = d;
        rx_count++;
      end else if (rx_count == FRAME_BYTES) begin
        rx_count = FRAME_BYTES + 1;
      end
      return 1'b0;
    end
    // Line idle: only a frame of exactly the right length decodes.
    if (rx_count != FRAME_BYTES) begin
      rx_count = 0;
      return 1'b0;
    end
    rx_count = 0;
    head = {rx_store[5], rx_store[4], rx_store[3], rx_store[2], rx_store[1], rx_store[0]};
    f.right_x   = center_stick(head[10:0]);
    f.right_y   = center_stick(head[21:11]);
    f.left_x    = center_stick(head[32:22]);
    f.left_y    = center_stick(head[43:33]);
    f.switches  = head[47:44];
    f.mouse_x   = {rx_store[7], rx_store[6]};
    f.mouse_y   = {rx_store[9], rx_store[8]};
    f.mouse_z   = {rx_store[11], rx_store[10]};
    f.btn_left  = rx_store[12];
    f.btn_right = rx_store[13];
    f.keys      = {rx_store[15], rx_store[14]};
    f.wheel     = {rx_store[17], rx_store[16]};
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // Compare each accepted result with the oldest predicted frame.
  always @(posedge clk_i) begin : result_check
    decoded_frame_t want;
    if (out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("result arrived with no frame expected");
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        check_field("stick_right_x", stick_right_x_o, want.right_x);
        check_field("stick_right_y", stick_right_y_o, want.right_y);
        check_field("stick_left_x", stick_left_x_o, want.left_x);
        check_field("stick_left_y", stick_left_y_o, want.left_y);
        check_field("switches", switches_o, want.switches);
        check_field("mouse_x", mouse_x_o, want.mouse_x);
        check_field("mouse_y", mouse_y_o, want.mouse_y);
        check_field("mouse_z", mouse_z_o, want.mouse_z);
        check_field("mouse_left", mouse_left_o, want.btn_left);
        check_field("mouse_right", mouse_right_o, want.btn_right);
        check_field("key_bits", key_bits_o, want.keys);
        check_field("wheel_value", wheel_value_o, want.wheel);
      end
    end
  end

  // Receiver stalls in random bursts while gaps are enabled.
  initial begin : ready_gen
    int hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        hold = $urandom_range(1, 4);
      end
      out_ready_i <= (hold == 0) && rst_ni;
    end
  end

  // Send one request, starting and ending at a falling edge; valid stays up afterwards.
  task automatic send_item(input logic m, input logic [7:0] d, input bit use_typed,
                           input decoded_frame_t typed_frame);
    bit             produced;
    decoded_frame_t f;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    rx_byte_i  <= d;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    produced = decode_step(m, d, f);
    if (use_typed) begin
      produced = 1'b1;
      f        = typed_frame;
    end
    if (produced) begin
      pending_frames.push_back(f);
    end
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every frame is out and the pipeline has emptied.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Write one register at the next rising edge; the caller lowers the write enable.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_CENTER_OFFSET: cfg_center = val;
      CFG_DEAD_ZONE:     cfg_dead   = val[9:0];
      CFG_CHANNEL_LIMIT: cfg_limit  = val[9:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Raw channel values near the interesting points of the current settings.
  function automatic logic [10:0] pick_channel();
    int c;
    int dz;
    int lim;
    int v;
    c   = int'(cfg_center);
    dz  = int'(cfg_dead);
    lim = int'(cfg_limit);
    case ($urandom_range(0, 6))
      0:       v = c - dz - 1 + int'($urandom_range(0, 2 * dz + 2));
      1:       v = c + lim - 1 + int'($urandom_range(0, 2));
      2:       v = c - lim - 1 + int'($urandom_range(0, 2));
      3:       v = 0;
      4:       v = 2047;
      5:       v = c;
      default: v = int'($urandom_range(0, 2047));
    endcase
    return 11'(v);
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Build the next frame's bytes: flat patterns, pure noise, or packed fields.
  task automatic fill_frame();
    logic [47:0] head;
    logic [15:0] w;
    int          i;
    int          style;
    style = $urandom_range(0, 9);
    for (i = 0; i < FRAME_BYTES; i++) begin
      if (style == 0) begin
        tx_frame[i] = 8'h00;
      end else if (style == 1) begin
        tx_frame[i] = 8'hFF;
      end else begin
        tx_frame[i] = 8'($urandom);
      end
    end
    if (style >= 4) begin
      head = {4'($urandom), pick_channel(), pick_channel(), pick_channel(), pick_channel()};
      for (i = 0; i < 6; i++) begin
        tx_frame[i] = head[8*i +: 8];
      end
      for (i = 6; i < FRAME_BYTES; i += 2) begin
        w             = pick_word();
        tx_frame[i]   = w[7:0];
        tx_frame[i+1] = w[15:8];
      end
      tx_frame[12] = 8'($urandom_range(0, 1));
      tx_frame[13] = 8'($urandom_range(0, 1));
    end
  endtask

  // Mostly complete frames; the rest short, overlong or stray requests.
  task automatic run_traffic(input int budget);
    int sent;
    int r;
    int n;
    int i;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      fill_frame();
      if (r < 80) begin
        n = FRAME_BYTES;
      end else if (r < 87) begin
        n = $urandom_range(0, FRAME_BYTES - 1);
      end else if (r < 94) begin
        n = $urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 4);
      end else begin
        n = -1;
      end
      if (n < 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_item(1'($urandom), 8'($urandom), 1'b0, '0);
          sent++;
        end
      end else begin
        for (i = 0; i < n; i++) begin
          send_item(MODE_DATA, (i < FRAME_BYTES) ? tx_frame[i] : 8'($urandom), 1'b0, '0);
        end
        send_item(MODE_IDLE, 8'($urandom), 1'b0, '0);
        sent += n + 1;
      end
    end
  endtask

  // Main sequence: reset, directed rows, then one traffic phase per register setting.
  initial begin : main_seq
    int fixed_center [4];
    int fixed_dead   [4];
    int fixed_limit  [4];
    int row;
    int k;
    int ph;
    int co;
    int dz;
    int lim;
    fixed_center = '{0, 2047, 1024, 1024};
    fixed_dead   = '{0, 1023, 700, 15};
    fixed_limit  = '{0, 1023, 300, 660};
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    mode_i         = MODE_DATA;
    rx_byte_i      = 8'h00;
    gaps_on        = 1'b1;
    mismatches     = 0;
    requests_sent  = 0;
    frames_checked = 0;
    cfg_center     = CENTER_OFFSET_RST;
    cfg_dead       = DEAD_ZONE_RST;
    cfg_limit      = CHANNEL_LIMIT_RST;
    rx_count       = 0;
    for (k = 0; k < FRAME_BYTES; k++) begin
      rx_store[k] = 8'h00;
    end
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows run under the reset settings.
    for (row = 0; row < 5; row++) begin
      for (k = 0; k < int'(DIRECTED_ROWS[row].reps); k++) begin
        send_item(DIRECTED_ROWS[row].mode, DIRECTED_ROWS[row].data,
                  DIRECTED_ROWS[row].has_frame, DIRECTED_ROWS[row].frame);
      end
    end
    settle();

    // Fixed extremes first, then random settings; the last phase runs without gaps.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 4) begin
        co  = fixed_center[ph];
        dz  = fixed_dead[ph];
        lim = fixed_limit[ph];
      end else begin
        co  = ($urandom_range(0, 1) == 0) ? 1024 + $urandom_range(0, 64) - 32
                                          : $urandom_range(0, 2047);
        dz  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 64);
        lim = $urandom_range(0, 1023);
      end
      write_reg(CFG_CENTER_OFFSET, 11'(co));
      write_reg(CFG_DEAD_ZONE, {1'($urandom), 10'(dz)});
      write_reg(CFG_CHANNEL_LIMIT, {1'($urandom), 10'(lim)});
      write_reg(CFG_SPARE_IDX, 11'($urandom));
      cfg_we_i <= 1'b0;
      @(negedge clk_i);
      gaps_on = (ph != NUM_PHASES - 1);
      run_traffic(PHASE_ITEMS);
      settle();
    end

    $display("Sent %0d requests over %0d register settings; %0d decoded frames checked.",
             requests_sent, NUM_PHASES + 1, frames_checked);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
